// ===== rtl/ced_pkg.sv =====
// ----------------------------------------------------------------------------
// ced_pkg
// Types, constants and helpers shared by the edge detector pipeline.
// ----------------------------------------------------------------------------
package ced_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WID_W      = COL_W + 1;
    localparam int HGT_W      = ROW_W + 1;
    localparam int LAG_W      = $clog2(3 * MAX_WIDTH + 4);

    typedef enum logic [1:0] {
        CFG_LOW    = 2'd0,
        CFG_HIGH   = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        DIR_HORZ  = 2'd0,
        DIR_D45   = 2'd1,
        DIR_VERT  = 2'd2,
        DIR_D135  = 2'd3
    } t_dir;

    typedef struct packed {
        logic       opcode;
        logic [7:0] pixel;
    } t_in;

    typedef struct packed {
        logic [7:0] edge_value;
        logic       frame_last;
    } t_out;

    typedef struct packed {
        logic             valid;
        logic             int_a;
        logic             int_b;
        logic             int_o;
        logic             last;
        logic             emit;
        logic [COL_W-1:0] acol;
        logic [COL_W-1:0] bcol;
    } t_ctl;

    // four steps of the bit-pair square root recurrence: returns {rem, root}
    function automatic logic [17:0] sqrt4(input logic [9:0] rem, input logic [7:0] root,
                                          input logic [7:0] bits);
        logic [11:0] rr;
        logic [9:0]  rm;
        logic [7:0]  rt;
        logic [11:0] trial;
        rm = rem;
        rt = root;
        for (int k = 0; k < 4; k++) begin
            rr    = {rm, bits[7-2*k -: 2]};
            trial = 12'({rt, 2'b01});
            if (rr >= trial) begin
                rr = rr - trial;
                rt = {rt[6:0], 1'b1};
            end else begin
                rt = {rt[6:0], 1'b0};
            end
            rm = rr[9:0];
        end
        return {rm, rt};
    endfunction

    function automatic t_dir dir_of(input logic signed [10:0] gx,
                                    input logic signed [10:0] gy);
        logic [10:0] ax;
        logic [10:0] ay;
        t_dir        d;
        ax = gx[10] ? 11'(-gx) : 11'(gx);
        ay = gy[10] ? 11'(-gy) : 11'(gy);
        if (gy == 11'sd0) begin
            d = DIR_HORZ;
        end else if (gx == 11'sd0) begin
            d = DIR_VERT;
        end else if (gx[10] == gy[10]) begin
            d = (ay <= ax) ? DIR_D45 : DIR_VERT;
        end else begin
            d = (ay >= ax) ? DIR_D135 : DIR_HORZ;
        end
        return d;
    endfunction

endpackage

// ===== rtl/canny_edge_detector_unit.sv =====
// ----------------------------------------------------------------------------
// canny_edge_detector_unit
// Streaming Canny edge detector: Sobel, suppression, double threshold.
// ----------------------------------------------------------------------------
// Takes one item per clock and gives one result per clock while the output
// side keeps up; the whole pipeline stalls only when a result waits at the
// output register. Each of the three stages keeps its two previous rows in a
// one-port-read, one-port-write line memory whose read is registered ahead of
// use, so a pixel's edge value comes out 3*(W+1) items later, behind the
// pipeline registers. Send flush items to drain the tail of a frame. Line
// memories need no clearing after reset.
module canny_edge_detector_unit import ced_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    logic [7:0]       r_low, r_high;
    logic [10:0]      r_width;
    logic [12:0]      r_height;
    logic [21:0]      r_count, n_count;
    logic [LAG_W-1:0] r_lag, n_lag;
    logic             r_home, n_home;
    logic [COL_W-1:0] r_vc, r_ac, r_bc, r_oc, n_vc, n_ac, n_bc, n_oc;
    logic [ROW_W-1:0] r_vr, r_ar, r_br, r_or, n_vr, n_ar, n_br, n_or;
    logic [COL_W-1:0] vc, ac, bc, oc;
    logic [ROW_W-1:0] vr, ar, br, orow;
    logic [WID_W-1:0] w;
    logic [HGT_W-1:0] h;
    logic [LAG_W-1:0] lim;
    logic             adv, take, flush, emit;
    logic [21:0]      cnt1;
    t_ctl             ent, g_ctl, m_ctl, t_ctl_o;
    logic [7:0]       g_mag, sup;
    t_dir             g_dir;
    logic             is_edge;
    logic             r_out_valid;
    t_out             r_out;

    function automatic logic inside_pos(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                                        input logic [WID_W-1:0] ww,
                                        input logic [HGT_W-1:0] hh);
        return (r != '0) && (HGT_W'(r) <= hh - HGT_W'(2))
            && (c != '0) && (WID_W'(c) <= ww - WID_W'(2));
    endfunction

    function automatic logic [COL_W+ROW_W-1:0] step(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c,
                                                    input logic [WID_W-1:0] ww,
                                                    input logic [HGT_W-1:0] hh);
        logic [ROW_W-1:0] nr;
        logic [COL_W-1:0] nc;
        nr = r;
        nc = c + COL_W'(1);
        if (WID_W'(c) == ww - WID_W'(1)) begin
            nc = '0;
            nr = (HGT_W'(r) == hh - HGT_W'(1)) ? '0 : r + ROW_W'(1);
        end
        return {nr, nc};
    endfunction

    assign adv         = !r_out_valid || i_out_ready;
    assign o_in_ready  = adv;
    assign o_cfg_ready = 1'b1;
    assign flush       = (i_in_data.opcode == OP_FLUSH);
    assign take        = i_in_valid && adv && !(flush && r_count == '0);

    always_comb begin
        w = (r_width < 11'd3) ? WID_W'(3)
          : (r_width > 11'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : r_width[WID_W-1:0];
        h = (r_height < 13'd3) ? HGT_W'(3)
          : (r_height > 13'(MAX_HEIGHT)) ? HGT_W'(MAX_HEIGHT) : r_height[HGT_W-1:0];
        lim = LAG_W'(w) + LAG_W'(w) + LAG_W'(w) + LAG_W'(3);
        if (r_home) begin
            vc = '0;
            vr = '0;
            ac = COL_W'(w - WID_W'(1));
            ar = ROW_W'(h - HGT_W'(2));
            bc = COL_W'(w - WID_W'(2));
            br = ROW_W'(h - HGT_W'(3));
            oc = COL_W'(w - WID_W'(3));
            orow = (h >= HGT_W'(4)) ? ROW_W'(h - HGT_W'(4)) : ROW_W'(2);
        end else begin
            vc = r_vc; vr = r_vr;
            ac = r_ac; ar = r_ar;
            bc = r_bc; br = r_br;
            oc = r_oc; orow = r_or;
        end
    end

    always_comb begin
        emit    = (r_lag >= lim);
        cnt1    = r_count + 22'(!flush);
        n_count = r_count;
        n_lag   = r_lag;
        n_home  = r_home;
        {n_vr, n_vc} = {vr, vc};
        {n_ar, n_ac} = {ar, ac};
        {n_br, n_bc} = {br, bc};
        {n_or, n_oc} = {orow, oc};
        if (take) begin
            n_home       = 1'b0;
            n_lag        = emit ? r_lag : r_lag + LAG_W'(1);
            n_count      = emit ? cnt1 - 22'd1 : cnt1;
            {n_vr, n_vc} = step(vr, vc, w, h);
            {n_ar, n_ac} = step(ar, ac, w, h);
            {n_br, n_bc} = step(br, bc, w, h);
            {n_or, n_oc} = step(orow, oc, w, h);
            if (emit && cnt1 == 22'd1) begin
                n_home = 1'b1;
                n_lag  = '0;
            end
        end
        ent.valid = take;
        ent.int_a = inside_pos(ar, ac, w, h);
        ent.int_b = inside_pos(br, bc, w, h);
        ent.int_o = inside_pos(orow, oc, w, h);
        ent.last  = (WID_W'(oc) == w - WID_W'(1)) && (HGT_W'(orow) == h - HGT_W'(1));
        ent.emit  = emit;
        ent.acol  = ac;
        ent.bcol  = bc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low    <= 8'd40;
            r_high   <= 8'd60;
            r_width  <= 11'd640;
            r_height <= 13'd480;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LOW:    r_low    <= i_cfg_data[7:0];
                CFG_HIGH:   r_high   <= i_cfg_data[7:0];
                CFG_WIDTH:  r_width  <= i_cfg_data[10:0];
                CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_lag   <= '0;
            r_home  <= 1'b1;
            r_vc <= '0; r_vr <= '0;
            r_ac <= '0; r_ar <= '0;
            r_bc <= '0; r_br <= '0;
            r_oc <= '0; r_or <= '0;
        end else begin
            r_count <= n_count;
            r_lag   <= n_lag;
            r_home  <= n_home;
            r_vc <= n_vc; r_vr <= n_vr;
            r_ac <= n_ac; r_ar <= n_ar;
            r_bc <= n_bc; r_br <= n_br;
            r_oc <= n_oc; r_or <= n_or;
        end
    end

    ced_grad u_grad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_ctl   (ent),
        .i_col   (vc),
        .i_pixel (flush ? 8'd0 : i_in_data.pixel),
        .o_ctl   (g_ctl),
        .o_mag   (g_mag),
        .o_dir   (g_dir)
    );

    ced_nms u_nms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_ctl   (g_ctl),
        .i_mag   (g_mag),
        .i_dir   (g_dir),
        .o_ctl   (m_ctl),
        .o_sup   (sup)
    );

    ced_thr u_thr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_ctl    (m_ctl),
        .i_sup    (sup),
        .i_low    (r_low),
        .i_high   (r_high),
        .o_ctl    (t_ctl_o),
        .o_strong (is_edge)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= t_ctl_o.valid && t_ctl_o.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.edge_value <= is_edge ? 8'd255 : 8'd0;
            r_out.frame_last <= t_ctl_o.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/ced_grad.sv =====
// ----------------------------------------------------------------------------
// ced_grad
// Pixel line memory, Sobel window, gradient, direction and pipelined sqrt.
// ----------------------------------------------------------------------------
module ced_grad import ced_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  t_ctl             i_ctl,
    input  logic [COL_W-1:0] i_col,
    input  logic [7:0]       i_pixel,
    output t_ctl             o_ctl,
    output logic [7:0]       o_mag,
    output t_dir             o_dir
);

    logic [15:0] mem [MAX_WIDTH];
    logic [15:0] r_rd;
    t_ctl        r_ctl1, r_ctl2, r_ctl3, r_ctl4;
    logic [COL_W-1:0] r_col1;
    logic [7:0]  r_fresh1;
    logic [7:0]  r_win [6];
    logic signed [10:0] r_gx, r_gy;
    t_dir        r_dir3, r_dir4;
    logic [20:0] r_sq;
    logic [7:0]  r_lo;
    logic        r_sat;
    logic [9:0]  r_rem;
    logic [7:0]  r_root;
    logic [7:0]  top, mid;
    logic [9:0]  gx_pos, gx_neg, gy_pos, gy_neg;
    logic signed [10:0] gx, gy;
    logic signed [21:0] sx, sy;
    logic [17:0] hi_res, lo_res;

    assign top = r_rd[15:8];
    assign mid = r_rd[7:0];

    always_comb begin
        gx_pos = 10'(top) + {1'b0, mid, 1'b0} + 10'(r_fresh1);
        gx_neg = 10'(r_win[0]) + {1'b0, r_win[1], 1'b0} + 10'(r_win[2]);
        gy_pos = 10'(r_win[0]) + {1'b0, r_win[3], 1'b0} + 10'(top);
        gy_neg = 10'(r_win[2]) + {1'b0, r_win[5], 1'b0} + 10'(r_fresh1);
        gx = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
        gy = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
        sx = r_gx * r_gx;
        sy = r_gy * r_gy;
        hi_res = sqrt4(10'd0, 8'd0, r_sq[15:8]);
        lo_res = sqrt4(r_rem, r_root, r_lo);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rd <= mem[i_col];
            if (r_ctl1.valid) begin
                mem[r_col1] <= {mid, r_fresh1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
            r_ctl4 <= '0;
            for (int j = 0; j < 6; j++) begin
                r_win[j] <= '0;
            end
        end else if (i_adv) begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
            r_ctl4 <= r_ctl3;
            if (r_ctl1.valid) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= top;
                r_win[4] <= mid;
                r_win[5] <= r_fresh1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_col1   <= i_col;
            r_fresh1 <= i_pixel;
            r_gx     <= r_ctl1.int_a ? gx : 11'sd0;
            r_gy     <= r_ctl1.int_a ? gy : 11'sd0;
            r_sq     <= sx[20:0] + sy[20:0];
            r_dir3   <= dir_of(r_gx, r_gy);
            r_sat    <= (r_sq[20:16] != 5'd0);
            r_rem    <= hi_res[17:8];
            r_root   <= hi_res[7:0];
            r_lo     <= r_sq[7:0];
            r_dir4   <= r_dir3;
        end
    end

    assign o_ctl = r_ctl4;
    assign o_mag = r_sat ? 8'd255 : lo_res[7:0];
    assign o_dir = r_dir4;

endmodule

// ===== rtl/ced_nms.sv =====
// ----------------------------------------------------------------------------
// ced_nms
// Magnitude line memory, direction line and non-maximum suppression.
// ----------------------------------------------------------------------------
module ced_nms import ced_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  t_ctl       i_ctl,
    input  logic [7:0] i_mag,
    input  t_dir       i_dir,
    output t_ctl       o_ctl,
    output logic [7:0] o_sup
);

    logic [15:0] mem [MAX_WIDTH];
    logic [1:0]  dmem [MAX_WIDTH];
    logic [15:0] r_rd;
    logic [1:0]  r_drd;
    t_ctl        r_ctl;
    logic [7:0]  r_mag;
    t_dir        r_dir;
    t_dir        r_hold;
    logic [7:0]  r_win [6];
    logic [7:0]  top, mid, c, p, n;

    assign top = r_rd[15:8];
    assign mid = r_rd[7:0];
    assign c   = r_win[4];

    always_comb begin
        case (t_dir'(r_drd))
            DIR_D45: begin
                p = top;
                n = r_win[2];
            end
            DIR_VERT: begin
                p = r_win[3];
                n = r_win[5];
            end
            DIR_D135: begin
                p = r_win[0];
                n = r_mag;
            end
            default: begin
                p = r_win[1];
                n = mid;
            end
        endcase
        o_sup = (!r_ctl.int_b || c < p || c < n) ? 8'd0 : c;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rd  <= mem[i_ctl.acol];
            r_drd <= dmem[i_ctl.bcol];
            r_mag <= i_mag;
            r_dir <= i_dir;
            if (r_ctl.valid) begin
                mem[r_ctl.acol]  <= {mid, r_mag};
                dmem[r_ctl.bcol] <= r_hold;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= '0;
            r_hold <= DIR_HORZ;
            for (int j = 0; j < 6; j++) begin
                r_win[j] <= '0;
            end
        end else if (i_adv) begin
            r_ctl <= i_ctl;
            if (r_ctl.valid) begin
                r_hold   <= r_dir;
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= top;
                r_win[4] <= mid;
                r_win[5] <= r_mag;
            end
        end
    end

    assign o_ctl = r_ctl;

endmodule

// ===== rtl/ced_thr.sv =====
// ----------------------------------------------------------------------------
// ced_thr
// Suppressed-value line memory and double thresholding.
// ----------------------------------------------------------------------------
module ced_thr import ced_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  t_ctl       i_ctl,
    input  logic [7:0] i_sup,
    input  logic [7:0] i_low,
    input  logic [7:0] i_high,
    output t_ctl       o_ctl,
    output logic       o_strong
);

    logic [15:0] mem [MAX_WIDTH];
    logic [15:0] r_rd;
    t_ctl        r_ctl;
    logic [7:0]  r_sup;
    logic [7:0]  r_win [6];
    logic [7:0]  top, mid, c;
    logic        nb;

    assign top = r_rd[15:8];
    assign mid = r_rd[7:0];
    assign c   = r_win[4];

    always_comb begin
        nb = (r_win[0] > i_high) || (r_win[1] > i_high) || (r_win[2] > i_high)
          || (r_win[3] > i_high) || (r_win[5] > i_high) || (top > i_high)
          || (mid > i_high) || (r_sup > i_high);
        if (!r_ctl.int_o || c < i_low) begin
            o_strong = 1'b0;
        end else if (c > i_high) begin
            o_strong = 1'b1;
        end else begin
            o_strong = nb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rd  <= mem[i_ctl.bcol];
            r_sup <= i_sup;
            if (r_ctl.valid) begin
                mem[r_ctl.bcol] <= {mid, r_sup};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
            for (int j = 0; j < 6; j++) begin
                r_win[j] <= '0;
            end
        end else if (i_adv) begin
            r_ctl <= i_ctl;
            if (r_ctl.valid) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= top;
                r_win[4] <= mid;
                r_win[5] <= r_sup;
            end
        end
    end

    assign o_ctl = r_ctl;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming edge detector. Frames of pixels go
// in under random idling on both sides, with flush items to drain each tail;
// a cycle-free model of the three stages predicts every edge value and end
// of frame flag, and each result is checked in order against it.
// ----------------------------------------------------------------------------
module tb;
    import ced_pkg::*;

    typedef logic [2:0][2:0][7:0] t_win;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [12:0] i_cfg_data;

    canny_edge_detector_unit dut (.*);

    // edge map model state
    logic [7:0]  lines [3][2*MAX_WIDTH];
    logic [1:0]  dir_line [MAX_WIDTH];
    logic [7:0]  win_regs [18];
    logic [1:0]  dir_hold;
    int unsigned col_pos, row_pos, pend_px, lag_fill;
    logic [7:0]  thr_low, thr_high;
    logic [10:0] img_w;
    logic [12:0] img_h;

    t_out        edge_q[$];
    int          n_err, n_res, n_frames, n_rand;
    bit          no_idle, hold_req;
    logic [7:0]  prev_px;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void slide(int st, int col, logic [7:0] fresh, output t_win w);
        w[0][2] = lines[st][col];
        w[1][2] = lines[st][MAX_WIDTH+col];
        w[2][2] = fresh;
        for (int j = 0; j < 3; j++) begin
            w[j][0] = win_regs[st*6+j];
            w[j][1] = win_regs[st*6+3+j];
            win_regs[st*6+j] = win_regs[st*6+3+j];
            win_regs[st*6+3+j] = w[j][2];
        end
        lines[st][col] = lines[st][MAX_WIDTH+col];
        lines[st][MAX_WIDTH+col] = fresh;
    endfunction

    function automatic bit is_inner(int unsigned p, int unsigned w, int unsigned h);
        int unsigned r, c;
        r = p / w;
        c = p % w;
        return r >= 1 && r + 2 <= h && c >= 1 && c + 2 <= w;
    endfunction

    function automatic logic [7:0] grad_mag(int unsigned s);
        int unsigned r, t;
        r = 0;
        if (s >= 65536) return 8'd255;
        for (int unsigned b = 128; b != 0; b >>= 1) begin
            t = r | b;
            if (t * t <= s) r = t;
        end
        return r[7:0];
    endfunction

    function automatic t_dir grad_dir(int gx, int gy);
        int ax, ay;
        ax = gx < 0 ? -gx : gx;
        ay = gy < 0 ? -gy : gy;
        if (gy == 0) return DIR_HORZ;
        if (gx == 0) return DIR_VERT;
        if ((gx > 0) == (gy > 0)) return ay <= ax ? DIR_D45 : DIR_VERT;
        return ay >= ax ? DIR_D135 : DIR_HORZ;
    endfunction

    function automatic bit predict_edge(t_in x, output t_out r);
        int unsigned wd, ht, fs, lat, v, a, b, o, nv;
        t_win        w;
        logic [7:0]  mag, sup, fresh, c, p, n;
        t_dir        dir, d;
        int          gx, gy;
        bit          emit;
        wd = img_w; ht = img_h;
        if (wd < 3) wd = 3;
        if (wd > MAX_WIDTH) wd = MAX_WIDTH;
        if (ht < 3) ht = 3;
        if (ht > MAX_HEIGHT) ht = MAX_HEIGHT;
        fs = wd * ht;
        lat = 3 * wd + 3;
        r = '0;
        mag = 0; sup = 0; dir = DIR_HORZ;
        if (x.opcode == OP_FLUSH && pend_px == 0) return 0;
        fresh = (x.opcode == OP_FLUSH) ? 8'd0 : x.pixel;
        v = (row_pos * wd + col_pos) % fs;
        a = (v + 2 * fs - (wd + 1)) % fs;
        b = (v + 2 * fs - 2 * (wd + 1)) % fs;
        o = (v + 2 * fs - 3 * (wd + 1)) % fs;

        slide(0, v % wd, fresh, w);
        if (is_inner(a, wd, ht)) begin
            gx = int'(w[0][2]) + 2 * int'(w[1][2]) + int'(w[2][2])
               - int'(w[0][0]) - 2 * int'(w[1][0]) - int'(w[2][0]);
            gy = int'(w[0][0]) + 2 * int'(w[0][1]) + int'(w[0][2])
               - int'(w[2][0]) - 2 * int'(w[2][1]) - int'(w[2][2]);
            mag = grad_mag(gx * gx + gy * gy);
            dir = grad_dir(gx, gy);
        end

        slide(1, a % wd, mag, w);
        d = t_dir'(dir_line[b % wd]);
        dir_line[b % wd] = dir_hold;
        dir_hold = dir;
        if (is_inner(b, wd, ht)) begin
            c = w[1][1];
            case (d)
                DIR_D45:  begin p = w[0][2]; n = w[2][0]; end
                DIR_VERT: begin p = w[0][1]; n = w[2][1]; end
                DIR_D135: begin p = w[0][0]; n = w[2][2]; end
                default:  begin p = w[1][0]; n = w[1][2]; end
            endcase
            sup = (c < p || c < n) ? 8'd0 : c;
        end

        slide(2, b % wd, sup, w);
        if (is_inner(o, wd, ht)) begin
            c = w[1][1];
            if (c < thr_low) begin
                r.edge_value = 8'd0;
            end else if (c > thr_high) begin
                r.edge_value = 8'd255;
            end else begin
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        if ((i != 1 || j != 1) && w[i][j] > thr_high) r.edge_value = 8'd255;
            end
        end

        if (x.opcode != OP_FLUSH) pend_px++;
        emit = lag_fill >= lat && pend_px > 0;
        if (lag_fill < lat) lag_fill++;
        nv = (v + 1) % fs;
        row_pos = nv / wd;
        col_pos = nv % wd;
        if (!emit) return 0;
        r.frame_last = (o == fs - 1);
        pend_px--;
        if (pend_px == 0) begin
            row_pos = 0;
            col_pos = 0;
            lag_fill = 0;
        end
        return 1;
    endfunction

    task automatic send_item(logic op, logic [7:0] px);
        t_in  x;
        t_out r;
        int   gap;
        x.opcode = op;
        x.pixel = px;
        gap = (!no_idle && $urandom_range(99) < 32) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= x;
        do @(posedge i_clk); while (!o_in_ready);
        if (predict_edge(x, r)) edge_q.push_back(r);
    endtask

    task automatic send_pixel(logic [7:0] px);
        send_item(OP_PIXEL, px);
    endtask

    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(3))
            0: prev_px = 8'($urandom_range(255));
            1: prev_px = 8'd0;
            2: prev_px = 8'd255;
            default: prev_px = prev_px + 8'($urandom_range(16)) - 8'd8;
        endcase
        return prev_px;
    endfunction

    task automatic drain_frame();
        while (pend_px != 0) send_item(OP_FLUSH, 8'($urandom_range(255)));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        wait (edge_q.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [12:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_LOW:   thr_low = val[7:0];
            CFG_HIGH:  thr_high = val[7:0];
            CFG_WIDTH: img_w = val[10:0];
            default:   img_h = val;
        endcase
        @(posedge i_clk);
    endtask

    task automatic setup(logic [12:0] lo, logic [12:0] hi, logic [12:0] w, logic [12:0] h);
        wait_idle();
        write_reg(CFG_LOW, lo);
        write_reg(CFG_HIGH, hi);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    task automatic test_directed();
        setup(40, 60, 3, 3);
        send_item(OP_FLUSH, 8'hFF);
        repeat (9) send_pixel(8'd0);
        repeat (9) send_pixel(8'd255);
        for (int i = 0; i < 9; i++) send_pixel((i % 3 == 0) ? 8'd255 : 8'd0);
        for (int i = 0; i < 9; i++) send_pixel((i < 3) ? 8'd255 : 8'd0);
        drain_frame();
        setup(200, 10, 5, 4);
        for (int i = 0; i < 20; i++) send_pixel(((i % 5) + (i / 5)) % 2 ? 8'd255 : 8'd0);
        repeat (4) send_item(OP_FLUSH, 8'h00);
        send_pixel(8'd128);
        drain_frame();
        setup(0, 0, 4, 5);
        for (int i = 0; i < 20; i++) send_pixel(8'(i * 13));
        drain_frame();
        setup(255, 255, 4, 4);
        for (int i = 0; i < 16; i++) send_pixel(8'($urandom_range(255)));
        drain_frame();
    endtask

    task automatic test_size_clamp();
        setup(30, 90, 0, 0);
        repeat (20) send_pixel(pick_pixel());
        drain_frame();
        setup(30, 90, 13'd4, 13'h1FFF);
        repeat (60) send_pixel(pick_pixel());
        drain_frame();
    endtask

    task automatic test_random_frames();
        int unsigned w, h, cnt;
        while (n_rand < 600) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 16);
            h = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 10);
            setup(13'($urandom_range(255)), 13'($urandom_range(255)), 13'(w), 13'(h));
            if (w < 3) w = 3;
            if (h < 3) h = 3;
            cnt = $urandom_range(1, 3 * w * h + 5);
            no_idle = ($urandom_range(5) == 0);
            for (int i = 0; i < cnt; i++) begin
                if ($urandom_range(19) == 0) send_item(OP_FLUSH, 8'($urandom_range(255)));
                else send_pixel(pick_pixel());
                n_rand++;
            end
            drain_frame();
            no_idle = 1'b0;
        end
    endtask

    task automatic test_backpressure();
        setup(20, 50, 8, 6);
        hold_req = 1'b1;
        repeat (300) send_pixel(pick_pixel());
        drain_frame();
    endtask

    task automatic test_sender_pause();
        setup(25, 70, 6, 5);
        repeat (60) send_pixel(pick_pixel());
        i_in_valid <= 1'b0;
        wait (edge_q.size() == 0);
        @(posedge i_clk);
        repeat (40) send_pixel(pick_pixel());
        drain_frame();
    endtask

    // output side: random stalls, plus a long hold-off when asked
    initial begin
        int hold_cnt;
        hold_cnt = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = 600;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= no_idle || ($urandom_range(99) >= 32);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_res++;
            if (edge_q.size() == 0) begin
                n_err++;
                $display("%0t: unexpected result %p", $time, o_out_data);
            end else begin
                if (o_out_data.edge_value !== edge_q[0].edge_value) begin
                    n_err++;
                    $display("%0t: edge_value expected %0d actual %0d", $time,
                             edge_q[0].edge_value, o_out_data.edge_value);
                end
                if (o_out_data.frame_last !== edge_q[0].frame_last) begin
                    n_err++;
                    $display("%0t: frame_last expected %0d actual %0d", $time,
                             edge_q[0].frame_last, o_out_data.frame_last);
                end
                if (o_out_data.frame_last === 1'b1) n_frames++;
                void'(edge_q.pop_front());
            end
        end
    end

    initial begin
        #4ms;
        $display("canny_edge_detector_unit test failed");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_LOW;
        i_cfg_data = '0;
        thr_low = 8'd40; thr_high = 8'd60; img_w = 11'd640; img_h = 13'd480;
        foreach (lines[s, k]) lines[s][k] = '0;
        foreach (dir_line[k]) dir_line[k] = '0;
        foreach (win_regs[k]) win_regs[k] = '0;
        dir_hold = '0;
        col_pos = 0; row_pos = 0; pend_px = 0; lag_fill = 0;
        n_err = 0; n_res = 0; n_frames = 0; n_rand = 0;
        no_idle = 1'b0; hold_req = 1'b0; prev_px = 8'd0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_size_clamp();
        test_backpressure();
        test_sender_pause();
        test_random_frames();

        wait_idle();
        $display("checked %0d edge results, %0d frame ends, %0d random items",
                 n_res, n_frames, n_rand);
        $display("frames from 3x3 up to a clamped 4096-row height, all registers and thresholds");
        if (n_err == 0) begin
            $display("canny_edge_detector_unit test passed");
        end else begin
            $display("canny_edge_detector_unit test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ced_pkg.sv
rtl/ced_grad.sv
rtl/ced_nms.sv
rtl/ced_thr.sv
rtl/canny_edge_detector_unit.sv
bench/tb.sv
